>>> rtl/mwps_pkg.sv
// Shared types and constants of the masked word pattern scanner.
// Depends on nothing; every other file of the block uses it.
package mwps_pkg;

	// field widths
	localparam int WORD_W   = 32;
	localparam int INDEX_W  = 4;
	localparam int LEN_W    = 5;
	localparam int CFG_IDX_W = 1;

	// default depth of the pattern and the window
	localparam int MAX_WORDS_DEF = 16;

	// byte address step of one word, as a shift
	localparam int WORD_BYTES_SHIFT = 2;

	// item operations
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_SCAN = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORDS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REGION_START  = 1'd1;

	// control of one window cell
	typedef struct packed {
		logic shift;   // take the neighbor's word
		logic clear;   // drop the word back to zero
	} cell_ctl_t;

	// control of the compare unit for one rotation step
	typedef struct packed {
		logic start;   // open a new window test
		logic valid;   // head word belongs to the pattern span
		logic first;   // head word is the first pattern word
	} step_t;

endpackage

>>> rtl/mwps_if.sv
// Valid/ready channels of the scanner: item input and result output.
// Depends on mwps_pkg for the field widths.
interface mwps_item_if;
	logic                          valid;
	logic                          ready;
	logic                          operation;
	logic [mwps_pkg::INDEX_W-1:0]  entry_index;
	logic [mwps_pkg::WORD_W-1:0]   pattern_word;
	logic [mwps_pkg::WORD_W-1:0]   mask_word;
	logic [mwps_pkg::WORD_W-1:0]   data_word;
	logic                          last;

	modport source (output valid, operation, entry_index, pattern_word, mask_word,
		data_word, last, input ready);
	modport sink (input valid, operation, entry_index, pattern_word, mask_word,
		data_word, last, output ready);
endinterface

interface mwps_result_if;
	logic                          valid;
	logic                          ready;
	logic                          found;
	logic [mwps_pkg::WORD_W-1:0]   match_address;

	modport source (output valid, found, match_address, input ready);
	modport sink (input valid, found, match_address, output ready);
endinterface

>>> rtl/mwps_cell.sv
// One cell of the window chain: holds one scanned word.
// Depends on mwps_pkg for the cell control struct.
module mwps_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mwps_pkg::cell_ctl_t         ctl,
	input  logic [mwps_pkg::WORD_W-1:0] nbr_word,
	output logic [mwps_pkg::WORD_W-1:0] word
);
	import mwps_pkg::*;

	logic [WORD_W-1:0] word_q;

	// clear wins over a shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else if (ctl.clear) begin
			word_q <= '0;
		end else if (ctl.shift) begin
			word_q <= nbr_word;
		end
	end

	assign word = word_q;
endmodule

>>> rtl/mwps_match.sv
// Pattern and mask store with the word comparator fed from the chain head.
// Depends on mwps_pkg for widths and the step struct.
module mwps_match #(
	parameter int MAX_WORDS = mwps_pkg::MAX_WORDS_DEF,
	localparam int IW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [IW-1:0]               wr_addr,
	input  logic [mwps_pkg::WORD_W-1:0] wr_pattern,
	input  logic [mwps_pkg::WORD_W-1:0] wr_mask,
	input  mwps_pkg::step_t             step,
	input  logic [IW-1:0]               rd_addr,
	input  logic [mwps_pkg::WORD_W-1:0] head_word,
	output logic                        match_ok
);
	import mwps_pkg::*;

	logic [WORD_W-1:0] pattern_mem [MAX_WORDS];
	logic [WORD_W-1:0] mask_mem [MAX_WORDS];
	logic [WORD_W-1:0] pattern_s1;
	logic [WORD_W-1:0] mask_s1;
	logic [WORD_W-1:0] head_s1;
	logic              valid_s1;
	logic              first_s1;
	logic              ok_q;
	logic              word_bad;

	// write on load beats, registered read on every cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			pattern_mem[wr_addr] <= wr_pattern;
			mask_mem[wr_addr]    <= wr_mask;
		end
		pattern_s1 <= pattern_mem[rd_addr];
		mask_s1    <= mask_mem[rd_addr];
		head_s1    <= head_word;
	end

	// stage flags travel with the read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			first_s1 <= 1'b0;
		end else begin
			valid_s1 <= step.valid;
			first_s1 <= step.first;
		end
	end

	// masked compare; the first word must match exactly
	assign word_bad = ((head_s1 & mask_s1) != (pattern_s1 & mask_s1))
		|| (first_s1 && (head_s1 != pattern_s1));

	// accumulate the verdict over the pattern span
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q <= 1'b0;
		end else if (step.start) begin
			ok_q <= 1'b1;
		end else if (valid_s1 && word_bad) begin
			ok_q <= 1'b0;
		end
	end

	assign match_ok = ok_q;
endmodule

>>> rtl/masked_word_pattern_scanner.sv
// Top level of the masked word pattern scanner: control, window chain, compare unit.
// Depends on mwps_pkg, mwps_if, mwps_cell and mwps_match.
//
//   port      dir   role
//   items     sink  load and scan beats (valid/ready)
//   results   src   found flag and match address (valid/ready)
//   cfg_*     in    register writes: pattern_words, region_start
//
// Load beats, and scan beats that cannot complete a window, are taken in idle;
// one that closes a region with no hit then waits in ST_PUT for its result. A
// beat that completes a window shifts in, rotates the chain once through the
// comparator, drains and decides, then puts a result on a hit or region end.
// A held result stalls the next result and the input behind it. Reset clears
// the window, counters and output registers; the pattern store is left unset.
module masked_word_pattern_scanner #(
	parameter int MAX_WORDS = mwps_pkg::MAX_WORDS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	mwps_item_if.sink                      items,
	mwps_result_if.source                  results,
	input  logic                           cfg_we,
	input  logic [mwps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mwps_pkg::WORD_W-1:0]    cfg_data
);
	import mwps_pkg::*;

	localparam int IW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int LW = $clog2(MAX_WORDS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROT,
		ST_DRAIN,
		ST_DONE,
		ST_PUT
	} state_t;

	state_t            state_q;
	logic [LEN_W-1:0]  pattern_words_q;
	logic [WORD_W-1:0] region_start_q;
	logic [WORD_W-1:0] words_seen_q;
	logic              reported_q;
	logic              last_q;
	logic [IW-1:0]     step_q;
	logic              res_found_q;
	logic [WORD_W-1:0] res_addr_q;
	logic              out_valid_q;
	logic              out_found_q;
	logic [WORD_W-1:0] out_addr_q;

	logic [LW-1:0]     len;
	logic [IW-1:0]     base;
	logic              accept;
	logic              scan_acc;
	logic              load_acc;
	logic              shift_in;
	logic              rotate;
	logic              eval_now;
	logic              chain_clear;
	logic [WORD_W-1:0] words_inc;
	logic [WORD_W-1:0] start_idx;
	logic [WORD_W-1:0] found_addr;
	logic [WORD_W-1:0] win [MAX_WORDS];
	logic [WORD_W-1:0] tail_feed;
	cell_ctl_t         cell_ctl;
	step_t             step;
	logic              match_ok;
	logic              slot_free;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_words_q <= LEN_W'(1);
			region_start_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PATTERN_WORDS: pattern_words_q <= cfg_data[LEN_W-1:0];
				REG_REGION_START:  region_start_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp the pattern length into 1..MAX_WORDS
	always_comb begin
		if (pattern_words_q == '0) begin
			len = LW'(1);
		end else if (32'(pattern_words_q) > 32'(MAX_WORDS)) begin
			len = LW'(MAX_WORDS);
		end else begin
			len = LW'(pattern_words_q);
		end
	end
	assign base = IW'(32'(MAX_WORDS) - 32'(len));

	// input handshake and scan decisions
	assign items.ready = (state_q == ST_IDLE);
	assign accept      = items.valid && items.ready;
	assign scan_acc    = accept && (items.operation == OP_SCAN);
	assign load_acc    = accept && (items.operation == OP_LOAD);
	assign shift_in    = scan_acc && !reported_q;
	assign words_inc   = (words_seen_q == '1) ? words_seen_q : words_seen_q + 32'd1;
	assign eval_now    = shift_in && (words_inc >= 32'(len));
	assign rotate      = (state_q == ST_ROT);
	assign chain_clear = (scan_acc && items.last && !eval_now)
		|| ((state_q == ST_DONE) && last_q);

	// window chain: shift in a new word, or rotate the head back to the tail
	assign tail_feed      = shift_in ? items.data_word : win[0];
	assign cell_ctl.shift = shift_in || rotate;
	assign cell_ctl.clear = chain_clear;

	for (genvar k = 0; k < MAX_WORDS; k++) begin : g_cell
		logic [WORD_W-1:0] nbr;
		if (k == MAX_WORDS - 1) begin : g_tail
			assign nbr = tail_feed;
		end else begin : g_body
			assign nbr = win[k + 1];
		end
		mwps_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (cell_ctl),
			.nbr_word (nbr),
			.word     (win[k])
		);
	end

	// compare the head word against pattern entry step - base
	assign step.start = eval_now;
	assign step.valid = rotate && (step_q >= base);
	assign step.first = rotate && (step_q == base);

	mwps_match #(
		.MAX_WORDS (MAX_WORDS)
	) u_match (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (load_acc && (32'(items.entry_index) < 32'(MAX_WORDS))),
		.wr_addr    (IW'(items.entry_index)),
		.wr_pattern (items.pattern_word),
		.wr_mask    (items.mask_word),
		.step       (step),
		.rd_addr    (step_q - base),
		.head_word  (win[0]),
		.match_ok   (match_ok)
	);

	// match address from the start index of the window
	assign start_idx  = words_seen_q - 32'(len);
	assign found_addr = region_start_q
		+ {start_idx[WORD_W-WORD_BYTES_SHIFT-1:0], {WORD_BYTES_SHIFT{1'b0}}};

	assign slot_free = !out_valid_q || results.ready;

	// sequencer, counters and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			words_seen_q <= '0;
			reported_q   <= 1'b0;
			last_q       <= 1'b0;
			step_q       <= '0;
			res_found_q  <= 1'b0;
			res_addr_q   <= '0;
			out_valid_q  <= 1'b0;
			out_found_q  <= 1'b0;
			out_addr_q   <= '0;
		end else begin
			// drop a taken beat unless a new result loads in its place
			if (results.valid && results.ready && !((state_q == ST_PUT) && slot_free)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (scan_acc) begin
						last_q <= items.last;
						if (eval_now) begin
							step_q  <= '0;
							state_q <= ST_ROT;
						end else if (!reported_q && items.last) begin
							res_found_q <= 1'b0;
							res_addr_q  <= '0;
							state_q     <= ST_PUT;
						end
						// close the region unless the window test still has to run
						if (items.last && !eval_now) begin
							words_seen_q <= '0;
							reported_q   <= 1'b0;
						end else if (!reported_q) begin
							words_seen_q <= words_inc;
						end
					end
				end
				ST_ROT: begin
					step_q <= step_q + IW'(1);
					if (step_q == IW'(MAX_WORDS - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (match_ok) begin
						res_found_q <= 1'b1;
						res_addr_q  <= found_addr;
						state_q     <= ST_PUT;
					end else if (last_q) begin
						res_found_q <= 1'b0;
						res_addr_q  <= '0;
						state_q     <= ST_PUT;
					end else begin
						state_q <= ST_IDLE;
					end
					// close the region, or hold off further scans after a hit
					if (last_q) begin
						words_seen_q <= '0;
						reported_q   <= 1'b0;
					end else if (match_ok) begin
						reported_q <= 1'b1;
					end
				end
				ST_PUT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_found_q <= res_found_q;
						out_addr_q  <= res_addr_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign results.valid         = out_valid_q;
	assign results.found         = out_found_q;
	assign results.match_address = out_addr_q;
endmodule
